// ===== design/bso_pkg.sv =====
`default_nettype none
package bso_pkg;

	localparam int MAX_SPHERES_DEF = 64;
	localparam int HEIGHT_FRAC_BITS = 5;
	localparam int HEIGHT_SHIFT = 8 - HEIGHT_FRAC_BITS;

	localparam int CENTER_W = 24;
	localparam int RADIUS_W = 23;
	localparam int ENTRY_W = 3 * CENTER_W + RADIUS_W;
	localparam int COORD_W = 27;
	localparam int GAP_W = 26;
	localparam int SQ_W = 2 * GAP_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int RSQ_W = 2 * RADIUS_W;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int MASK_W = 64;

	localparam logic [15:0] SQUARE_SIZE_RST = 16'd2048;
	localparam logic [3:0] LEVEL_MAX = 4'd8;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SPHERE_COUNT = 2'd0,
		CFG_SQUARE_SIZE  = 2'd1,
		CFG_ORIGIN_X     = 2'd2,
		CFG_ORIGIN_Y     = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [GAP_W-1:0] gap_t;

	typedef struct packed {
		coord_t x0;
		coord_t x1;
		coord_t y0;
		coord_t y1;
		coord_t z0;
		coord_t z1;
	} box_t;

	typedef struct packed {
		logic hit_valid;
		logic hit;
		logic busy;
	} dist_status_t;

	// distance from p to the span [lo, hi], zero inside; lo is checked first
	function automatic gap_t axis_gap(coord_t p, coord_t lo, coord_t hi);
		coord_t diff;
		diff = '0;
		if (p < lo) begin
			diff = lo - p;
		end else if (p > hi) begin
			diff = p - hi;
		end
		return diff[GAP_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/bso_ram.sv =====
`default_nettype none
module bso_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_W-1:0]    waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [ADDR_W-1:0]    raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/bso_dist.sv =====
`default_nettype none
module bso_dist #(
	parameter int MAX_SPHERES = bso_pkg::MAX_SPHERES_DEF,
	localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [IDX_W-1:0]             in_idx,
	input  wire logic [bso_pkg::ENTRY_W-1:0]  entry,
	input  wire bso_pkg::box_t                box,
	output bso_pkg::dist_status_t             status,
	output logic      [IDX_W-1:0]             out_idx
);

	localparam int CW = bso_pkg::CENTER_W;
	localparam int RW = bso_pkg::RADIUS_W;

	bso_pkg::coord_t cx, cy, cz;
	logic [RW-1:0] radius;

	logic valid_s2, valid_s3, valid_s4;
	logic [IDX_W-1:0] idx_s2, idx_s3, idx_s4;
	bso_pkg::gap_t dx_s2, dy_s2, dz_s2;
	logic [RW-1:0] r_s2;
	logic [bso_pkg::SQ_W-1:0] dx2_s3, dy2_s3, dz2_s3;
	logic [bso_pkg::RSQ_W-1:0] r2_s3;
	logic hit_s4;
	logic [bso_pkg::SUM_W-1:0] d2;

	// entry layout: x, y, z, radius from the top
	assign cx = bso_pkg::COORD_W'($signed(entry[bso_pkg::ENTRY_W-1 -: CW]));
	assign cy = bso_pkg::COORD_W'($signed(entry[bso_pkg::ENTRY_W-CW-1 -: CW]));
	assign cz = bso_pkg::COORD_W'($signed(entry[RW +: CW]));
	assign radius = entry[RW-1:0];

	assign d2 = bso_pkg::SUM_W'(dx2_s3) + bso_pkg::SUM_W'(dy2_s3) + bso_pkg::SUM_W'(dz2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= in_idx;
		dx_s2 <= bso_pkg::axis_gap(cx, box.x0, box.x1);
		dy_s2 <= bso_pkg::axis_gap(cy, box.y0, box.y1);
		dz_s2 <= bso_pkg::axis_gap(cz, box.z0, box.z1);
		r_s2 <= radius;

		idx_s3 <= idx_s2;
		dx2_s3 <= bso_pkg::SQ_W'(dx_s2) * bso_pkg::SQ_W'(dx_s2);
		dy2_s3 <= bso_pkg::SQ_W'(dy_s2) * bso_pkg::SQ_W'(dy_s2);
		dz2_s3 <= bso_pkg::SQ_W'(dz_s2) * bso_pkg::SQ_W'(dz_s2);
		r2_s3 <= bso_pkg::RSQ_W'(r_s2) * bso_pkg::RSQ_W'(r_s2);

		idx_s4 <= idx_s3;
		hit_s4 <= d2 < bso_pkg::SUM_W'(r2_s3);
	end

	assign status.hit_valid = valid_s4;
	assign status.hit = hit_s4;
	assign status.busy = valid_s2 | valid_s3 | valid_s4;
	assign out_idx = idx_s4;

endmodule
`default_nettype wire

// ===== design/box_sphere_overlap_mask.sv =====
// sphere table with box overlap test
//
// one command channel: start is taken at a rising edge where busy is low.
// operation selects the transaction: a write stores the sphere at
// entry_index and leaves busy low, so writes can follow back
// to back; a test latches the square and test_mask and raises busy.
// a test forms the box in a setup state, then reads the sphere table one
// entry per cycle through the single read port of the table memory into
// the shared distance pipeline, and drains it. done pulses for
// one cycle with hit_mask valid once the drain ends, that is once no
// tested entry is left in flight; the scan covers N entries, where N is
// sphere_count clamped to MAX_SPHERES.
// start may be given again in the done cycle.
// the receiver cannot stall: hit_mask is only guaranteed during done.
// configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are expected only while busy is low.
// reset clears the sequencer and configuration, square_size to 2048;
// table contents stay undefined until written.
`default_nettype none
module box_sphere_overlap_mask #(
	parameter int MAX_SPHERES = bso_pkg::MAX_SPHERES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	output logic                                   done,
	input  wire logic                              cfg_we,
	input  wire logic [bso_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [bso_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              operation,
	input  wire logic [5:0]                        entry_index,
	input  wire logic signed [23:0]                center_x,
	input  wire logic signed [23:0]                center_y,
	input  wire logic signed [23:0]                center_z,
	input  wire logic [22:0]                       radius,
	input  wire logic [7:0]                        grid_x,
	input  wire logic [7:0]                        grid_y,
	input  wire logic [3:0]                        level,
	input  wire logic [15:0]                       low_height,
	input  wire logic [15:0]                       high_height,
	input  wire logic [bso_pkg::MASK_W-1:0]        test_mask,
	output logic      [bso_pkg::MASK_W-1:0]        hit_mask
);

	localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CNT_W = $clog2(MAX_SPHERES + 1);

	bso_pkg::state_t state_q, state_d;

	logic [6:0] sphere_count_q;
	logic [15:0] square_size_q;
	logic signed [23:0] origin_x_q, origin_y_q;

	logic [7:0] grid_x_q, grid_y_q;
	logic [3:0] level_q;
	logic [15:0] low_q, high_q;
	logic [MAX_SPHERES-1:0] mask_q;
	logic [MAX_SPHERES-1:0] hits_q;
	logic [CNT_W-1:0] count_q, scan_q;
	bso_pkg::box_t box_q;
	logic done_q, done_d;

	logic accept, test_go, write_go, issue, pipe_empty;
	logic issue_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [bso_pkg::ENTRY_W-1:0] rd_entry;
	bso_pkg::dist_status_t dist_status;
	logic [IDX_W-1:0] hit_idx;

	logic [3:0] lvl_c;
	logic [23:0] cell_x, cell_y, side, z_lo, z_hi;
	bso_pkg::coord_t x0, y0;

	assign accept = start && !busy;
	assign test_go = accept && (operation == bso_pkg::OP_TEST);
	assign write_go = accept && (operation == bso_pkg::OP_WRITE) &&
		({1'b0, entry_index} < 7'(MAX_SPHERES));

	assign issue = (state_q == bso_pkg::ST_SCAN) && (scan_q != count_q);
	assign pipe_empty = !issue_s1 && !dist_status.busy;

	// box setup
	assign lvl_c = (level_q > bso_pkg::LEVEL_MAX) ? bso_pkg::LEVEL_MAX : level_q;
	assign cell_x = 24'(grid_x_q) * 24'(square_size_q);
	assign cell_y = 24'(grid_y_q) * 24'(square_size_q);
	assign side = 24'(square_size_q) << lvl_c;
	assign z_lo = 24'(low_q) << bso_pkg::HEIGHT_SHIFT;
	assign z_hi = 24'(high_q) << bso_pkg::HEIGHT_SHIFT;
	assign x0 = $signed({3'b000, cell_x}) + bso_pkg::COORD_W'(origin_x_q);
	assign y0 = $signed({3'b000, cell_y}) + bso_pkg::COORD_W'(origin_y_q);

	always_comb begin
		state_d = state_q;
		done_d = 1'b0;
		unique case (state_q)
			bso_pkg::ST_IDLE: begin
				if (test_go) begin
					state_d = bso_pkg::ST_SETUP;
				end
			end
			bso_pkg::ST_SETUP: begin
				state_d = bso_pkg::ST_SCAN;
			end
			bso_pkg::ST_SCAN: begin
				if (scan_q == count_q) begin
					state_d = bso_pkg::ST_DRAIN;
				end
			end
			bso_pkg::ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = bso_pkg::ST_IDLE;
					done_d = 1'b1;
				end
			end
			default: begin
				state_d = bso_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bso_pkg::ST_IDLE;
			done_q <= 1'b0;
			issue_s1 <= 1'b0;
			scan_q <= '0;
			count_q <= '0;
			hits_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
			issue_s1 <= issue && mask_q[scan_q[IDX_W-1:0]];
			if (test_go) begin
				scan_q <= '0;
				hits_q <= '0;
				count_q <= (sphere_count_q > 7'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES) :
					sphere_count_q[CNT_W-1:0];
			end else if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (dist_status.hit_valid && dist_status.hit) begin
				hits_q[hit_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_count_q <= '0;
			square_size_q <= bso_pkg::SQUARE_SIZE_RST;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bso_pkg::CFG_SPHERE_COUNT: sphere_count_q <= cfg_data[6:0];
				bso_pkg::CFG_SQUARE_SIZE:  square_size_q <= cfg_data[15:0];
				bso_pkg::CFG_ORIGIN_X:     origin_x_q <= $signed(cfg_data);
				bso_pkg::CFG_ORIGIN_Y:     origin_y_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (test_go) begin
			grid_x_q <= grid_x;
			grid_y_q <= grid_y;
			level_q <= level;
			low_q <= low_height;
			high_q <= high_height;
			mask_q <= test_mask[MAX_SPHERES-1:0];
		end
		if (state_q == bso_pkg::ST_SETUP) begin
			box_q.x0 <= x0;
			box_q.x1 <= x0 + $signed({3'b000, side});
			box_q.y0 <= y0;
			box_q.y1 <= y0 + $signed({3'b000, side});
			box_q.z0 <= $signed({3'b000, z_lo});
			box_q.z1 <= $signed({3'b000, z_hi});
		end
		idx_s1 <= scan_q[IDX_W-1:0];
	end

	bso_ram #(
		.WIDTH(bso_pkg::ENTRY_W),
		.DEPTH(MAX_SPHERES)
	) u_table (
		.clk  (clk),
		.we   (write_go),
		.waddr(entry_index[IDX_W-1:0]),
		.wdata({center_x, center_y, center_z, radius}),
		.raddr(scan_q[IDX_W-1:0]),
		.rdata(rd_entry)
	);

	bso_dist #(
		.MAX_SPHERES(MAX_SPHERES)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(issue_s1),
		.in_idx  (idx_s1),
		.entry   (rd_entry),
		.box     (box_q),
		.status  (dist_status),
		.out_idx (hit_idx)
	);

	assign busy = (state_q != bso_pkg::ST_IDLE);
	assign done = done_q;
	assign hit_mask = bso_pkg::MASK_W'(hits_q);

endmodule
`default_nettype wire

// ===== design/bso_checker.sv =====
`default_nettype none
module bso_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic operation
);

	// result strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held longer than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");

	// a test transaction occupies the block
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == bso_pkg::OP_TEST) |=> busy)
		else $error("test transaction did not raise busy");

	// a write transaction completes at once with no result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == bso_pkg::OP_WRITE) |=> (!busy && !done))
		else $error("write transaction disturbed busy or done");

endmodule

bind box_sphere_overlap_mask bso_checker u_bso_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.operation(operation)
);
`default_nettype wire
